// ===== rtl/core/bspu_pkg.sv =====
// Package for the branch target buffer with a static direction policy.
// Holds geometry constants, payload and command structs, and state codes.
// No dependencies.
`timescale 1ns / 1ps

package bspu_pkg;

	localparam int SET_BITS    = 4;
	localparam int OFFSET_BITS = 2;
	localparam int WAYS        = 4;
	localparam int NUM_SETS    = 1 << SET_BITS;
	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENTRY_W     = 64;

	localparam logic [31:0] SEQ_STEP = 32'h0000_0004;

	// Direction policy codes; the remaining codes select backward taken, forward not taken.
	localparam logic [1:0] MODE_TAKEN     = 2'd0;
	localparam logic [1:0] MODE_NOT_TAKEN = 2'd1;
	localparam logic [1:0] MODE_RESET     = 2'd2;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] next_pc;
		logic        is_branch;
	} bspu_req_t;

	typedef struct packed {
		logic        btb_hit;
		logic [31:0] predicted_pc;
		logic        prediction_correct;
		logic [31:0] correct_count;
		logic [31:0] transfer_count;
	} bspu_rsp_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic cfg_we;
	} bspu_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} bspu_state_t;

endpackage

// ===== rtl/core/bspu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the tag and target storage of each way. No dependencies.
`timescale 1ns / 1ps

module bspu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/bspu_ctrl.sv =====
// Controller of the branch target buffer: sequences lookup and commit and
// owns the result valid flag. Depends on bspu_pkg.
`timescale 1ns / 1ps

module bspu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output bspu_pkg::bspu_cmd_t cmd
);

	import bspu_pkg::*;

	bspu_state_t state_q;
	bspu_state_t state_d;
	logic        rsp_valid_q;
	logic        out_free;

	// The result register can take a new item when empty or draining this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall  = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign cmd.accept = (state_q == ST_IDLE) && req_valid;
	assign cmd.commit = (state_q == ST_EVAL) && out_free;
	assign cmd.cfg_we = cfg_valid && cfg_ready;
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/bspu_datapath.sv =====
// Datapath of the branch target buffer: way RAMs, valid bits, tag compare,
// prediction, counters and the result register. Depends on bspu_pkg, bspu_ram.
`timescale 1ns / 1ps

module bspu_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bspu_pkg::bspu_cmd_t cmd,
	input  bspu_pkg::bspu_req_t req,
	input  logic [1:0]          predict_mode,
	output bspu_pkg::bspu_rsp_t rsp
);

	import bspu_pkg::*;

	bspu_req_t                          item_q;
	bspu_rsp_t                          rsp_q;
	logic [1:0]                         mode_q;
	logic [NUM_SETS-1:0][WAYS-1:0]      valid_q;
	logic [WAY_W-1:0]                   victim_q;
	logic [31:0]                        correct_q;
	logic [31:0]                        transfer_q;

	logic [ENTRY_W-1:0]                 rd_data [WAYS];
	logic [SET_BITS-1:0]                rd_set;
	logic [SET_BITS-1:0]                set_idx;
	logic [WAYS-1:0]                    set_valid;
	logic                               found;
	logic [31:0]                        tgt;
	logic                               hit;
	logic                               fill;
	logic [31:0]                        seq_pc;
	logic [31:0]                        pred;
	logic                               ok;
	logic [31:0]                        correct_d;
	logic [31:0]                        transfer_d;

	assign rd_set    = req.pc[OFFSET_BITS +: SET_BITS];
	assign set_idx   = item_q.pc[OFFSET_BITS +: SET_BITS];
	assign set_valid = valid_q[set_idx];

	for (genvar w = 0; w < WAYS; w++) begin : g_way
		bspu_ram #(
			.WIDTH(ENTRY_W),
			.DEPTH(NUM_SETS)
		) u_ram (
			.clk  (clk),
			.we   (fill && (victim_q == WAY_W'(w))),
			.waddr(set_idx),
			.wdata({item_q.pc, item_q.next_pc}),
			.re   (cmd.accept),
			.raddr(rd_set),
			.rdata(rd_data[w])
		);
	end

	// The lowest-numbered valid way whose tag equals the pc wins.
	always_comb begin
		found = 1'b0;
		tgt   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && set_valid[w] && (rd_data[w][ENTRY_W-1 -: 32] == item_q.pc)) begin
				found = 1'b1;
				tgt   = rd_data[w][31:0];
			end
		end
	end

	assign hit    = item_q.is_branch && found;
	assign fill   = cmd.commit && item_q.is_branch && !found;
	assign seq_pc = item_q.pc + SEQ_STEP;

	always_comb begin
		pred = '0;
		if (hit) begin
			case (mode_q)
				MODE_TAKEN:     pred = tgt;
				MODE_NOT_TAKEN: pred = seq_pc;
				default:        pred = (tgt < item_q.pc) ? tgt : seq_pc;
			endcase
		end
	end

	assign ok = hit && (pred == item_q.next_pc);

	always_comb begin
		correct_d  = correct_q;
		transfer_d = transfer_q;
		if (ok && (correct_q != '1)) begin
			correct_d = correct_q + 32'd1;
		end
		if ((item_q.next_pc != seq_pc) && (transfer_q != '1)) begin
			transfer_d = transfer_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req;
		end
		if (cmd.commit) begin
			rsp_q.btb_hit            <= hit;
			rsp_q.predicted_pc       <= pred;
			rsp_q.prediction_correct <= ok;
			rsp_q.correct_count      <= correct_d;
			rsp_q.transfer_count     <= transfer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESET;
			valid_q    <= '0;
			victim_q   <= '0;
			correct_q  <= '0;
			transfer_q <= '0;
		end else begin
			if (cmd.cfg_we) begin
				mode_q <= predict_mode;
			end
			if (cmd.commit) begin
				correct_q  <= correct_d;
				transfer_q <= transfer_d;
			end
			if (fill) begin
				valid_q[set_idx][victim_q] <= 1'b1;
				victim_q <= (victim_q == WAY_W'(WAYS - 1)) ? '0 : victim_q + 1'b1;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/btb_static_branch_predictor_unit.sv =====
// An item's set is read from the way RAMs at accept; the compare and commit state then scores it
// and loads the result register, and a stalled result holds the commit. The block takes no new
// item until the current one has committed.
// Reset (arst_n low, asynchronous) clears the entry valid bits, the victim pointer,
// both counters and the result valid flag, and sets the policy to backward taken.
// The tag and target RAMs need no clearing pass: an entry is never used while invalid.
`timescale 1ns / 1ps

module btb_static_branch_predictor_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bspu_pkg::bspu_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bspu_pkg::bspu_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          predict_mode
);

	import bspu_pkg::*;

	// Command bundle from the controller to the datapath. The accept command
	// captures the item and starts the RAM read of its set. The commit command
	// scores the prediction, fills a way on a branch miss, updates the counters
	// and loads the result register.
	bspu_cmd_t cmd;

	// The controller takes a new item only while idle. Once the item has been
	// looked up, it commits as soon as the result register is empty or being
	// drained. While a stalled result holds the commit, the input stays stalled.
	bspu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cmd      (cmd)
	);

	// The datapath holds one tag and target RAM per way, indexed by the set
	// bits of the pc, plus one valid flip-flop per entry. The full pc is the
	// tag. Misses replace the way chosen by a single round-robin pointer.
	bspu_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req         (req),
		.predict_mode(predict_mode),
		.rsp         (rsp)
	);

endmodule

// ===== rtl/core/bspu_checker.sv =====
// Port-level checks for the branch target buffer, bound to the top level.
// Depends on bspu_pkg and btb_static_branch_predictor_unit.
`timescale 1ns / 1ps

module bspu_port_checks (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input bspu_pkg::bspu_rsp_t rsp
);

	// A stalled result holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// A correct prediction is only possible on a hit.
	a_correct_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.prediction_correct |-> rsp.btb_hit)
		else $error("correct prediction without a hit");

	// A miss or non-branch reports a zero prediction.
	a_miss_zero_pred: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.btb_hit |-> rsp.predicted_pc == 32'd0)
		else $error("nonzero prediction on a miss");

	// The block works on one item at a time: it stalls the cycle after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item accepted while one is in flight");

endmodule

bind btb_static_branch_predictor_unit bspu_port_checks u_bspu_port_checks (.*);
